// ===== sv/kde_element_search_core_assert.svh =====
// Assertion helpers for the key-data element search core.
`ifndef KDE_ELEMENT_SEARCH_CORE_ASSERT_SVH
`define KDE_ELEMENT_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define KDES_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("kdes assertion failed");

// Next-cycle implication, disabled while in reset.
`define KDES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("kdes assertion failed");

`endif

// ===== sv/kdes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kdes_pkg;

  localparam int unsigned OUI_W     = 24;
  localparam int unsigned TYPE_W    = 8;
  localparam int unsigned LEN_W     = 9;
  localparam int unsigned FLEN_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OUI       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DATA_TYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_LEN   = 2'd2;

  localparam logic [OUI_W-1:0]  OUI_RESET       = 24'h000FAC;
  localparam logic [TYPE_W-1:0] DATA_TYPE_RESET = 8'd1;
  localparam logic [LEN_W-1:0]  MIN_LEN_RESET   = 9'd6;

  // Element header: type, length, three OUI bytes, data type.
  localparam logic [LEN_W-1:0]  HDR_LEN  = 9'd6;
  localparam logic [TYPE_W-1:0] KDE_MARK = 8'hDD;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_WALK   = 4'b0010,
    PH_STREAM = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [OUI_W-1:0]  match_oui;
    logic [TYPE_W-1:0] match_data_type;
    logic [LEN_W-1:0]  min_len;
  } cfg_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_offset;
    logic       payload_last;
    logic       outcome_valid;
    logic       found;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/kdes_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdes_cfg_regs
  import kdes_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 we_i,
  input  wire logic [CFG_IDX_W-1:0] idx_i,
  input  wire logic [OUI_W-1:0]     wdata_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        CFG_IDX_OUI:       cfg_d.match_oui       = wdata_i;
        CFG_IDX_DATA_TYPE: cfg_d.match_data_type = wdata_i[TYPE_W-1:0];
        CFG_IDX_MIN_LEN:   cfg_d.min_len         = wdata_i[LEN_W-1:0];
        default:           cfg_d = cfg_q;  // no register at this index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_oui       <= OUI_RESET;
      cfg_q.match_data_type <= DATA_TYPE_RESET;
      cfg_q.min_len         <= MIN_LEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/kdes_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kdes_walker
  import kdes_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic [FLEN_W-1:0] flen_i,
  input  wire logic              first_i,
  input  wire cfg_t              cfg_i,
  output result_t                res_o
);

  logic [FLEN_W-1:0] br_q, br_d;
  logic [LEN_W-1:0]  el_q, el_d;
  logic [LEN_W-1:0]  off_q, off_d;
  logic [TYPE_W-1:0] typ_q, typ_d;
  logic              hm_q, hm_d;
  phase_e            ph_q, ph_d;

  always_comb begin
    logic [FLEN_W-1:0] br_e;
    logic [LEN_W-1:0]  el_e, off_e, el_cur, eff_min, str_off;
    logic [TYPE_W-1:0] typ_e;
    logic              hm_e, hm_new, halt;
    logic [FLEN_W-1:0] rest;
    logic [LEN_W:0]    off_inc;
    logic [7:0]        want;

    // A first byte restarts from a clean element state.
    br_e  = first_i ? flen_i : br_q;
    el_e  = first_i ? '0 : el_q;
    off_e = first_i ? '0 : off_q;
    typ_e = first_i ? '0 : typ_q;
    hm_e  = first_i ? 1'b0 : hm_q;

    br_d  = br_e;
    el_d  = el_e;
    off_d = off_e;
    typ_d = typ_e;
    hm_d  = hm_e;
    ph_d  = ph_q;
    res_o = '0;

    eff_min = (cfg_i.min_len < HDR_LEN) ? HDR_LEN : cfg_i.min_len;
    el_cur  = (off_e == 9'd1) ? ({1'b0, byte_i} + 9'd2) : el_e;
    rest    = br_e - {{(FLEN_W-LEN_W){1'b0}}, el_cur};
    off_inc = {1'b0, off_e} + 10'd1;
    hm_new  = hm_e;
    halt    = 1'b0;
    str_off = off_q - HDR_LEN;

    unique case (off_e[1:0])
      2'd2:    want = cfg_i.match_oui[23:16];
      2'd3:    want = cfg_i.match_oui[15:8];
      default: want = cfg_i.match_oui[7:0];
    endcase

    if (first_i && (flen_i < {{(FLEN_W-LEN_W){1'b0}}, HDR_LEN})) begin
      res_o.outcome_valid = 1'b1;
      ph_d = PH_DONE;
    end else if (first_i || (ph_q == PH_WALK)) begin
      ph_d = PH_WALK;
      case (off_e) inside
        9'd0: begin
          typ_d = byte_i;
          hm_d  = 1'b1;
        end
        9'd1: begin
          el_d = el_cur;
          if (((typ_e == KDE_MARK) && (el_cur < HDR_LEN)) ||
              ({{(FLEN_W-LEN_W){1'b0}}, el_cur} > br_e)) begin
            halt = 1'b1;
          end else if ((el_cur < eff_min) &&
                       (rest < {{(FLEN_W-LEN_W){1'b0}}, HDR_LEN})) begin
            halt = 1'b1;
          end
          if (halt) begin
            res_o.outcome_valid = 1'b1;
            ph_d = PH_DONE;
          end
        end
        9'd2, 9'd3, 9'd4: begin
          if (byte_i != want) hm_d = 1'b0;
        end
        9'd5: begin
          hm_new = hm_e & (byte_i == cfg_i.match_data_type);
          hm_d   = hm_new;
          if (el_e >= eff_min) begin
            if (hm_new) begin
              halt = 1'b1;
              res_o.outcome_valid = 1'b1;
              res_o.found = 1'b1;
              ph_d = PH_DONE;
              // Stream the data bytes when the element carries any.
              if (el_e > HDR_LEN) begin
                ph_d  = PH_STREAM;
                off_d = HDR_LEN;
              end
            end else if (rest < {{(FLEN_W-LEN_W){1'b0}}, HDR_LEN}) begin
              halt = 1'b1;
              res_o.outcome_valid = 1'b1;
              ph_d = PH_DONE;
            end
          end
        end
        default: ;
      endcase
      if (!halt) begin
        // Advance to the next element at its last byte.
        if ((off_e != '0) && (off_inc >= {1'b0, el_cur})) begin
          br_d  = rest;
          off_d = '0;
        end else begin
          off_d = off_inc[LEN_W-1:0];
        end
      end
    end else if (ph_q == PH_STREAM) begin
      res_o.payload_valid  = 1'b1;
      res_o.payload_byte   = byte_i;
      res_o.payload_offset = str_off[7:0];
      if (off_inc >= {1'b0, el_q}) begin
        res_o.payload_last = 1'b1;
        ph_d = PH_DONE;
      end else begin
        off_d = off_inc[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      br_q  <= '0;
      el_q  <= '0;
      off_q <= '0;
      typ_q <= '0;
      hm_q  <= 1'b0;
      ph_q  <= PH_IDLE;
    end else if (step_i) begin
      br_q  <= br_d;
      el_q  <= el_d;
      off_q <= off_d;
      typ_q <= typ_d;
      hm_q  <= hm_d;
      ph_q  <= ph_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/kde_element_search_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: input register, then result register, which loads when the input stage advances.
// Throughput: one byte per cycle unless stalled; the element walker updates its state per step.
// Each accepted byte yields exactly one result transfer; input stalls only on output backpressure.
// Reset (rst_ni low, asynchronous): both stages empty, search idle until a first byte,
// configuration registers back to their reset values.

`include "kde_element_search_core_assert.svh"

module kde_element_search_core
  import kdes_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [23:0]          s_axis_tdata,  // data_byte[7:0], frame_length[23:8]
  input  wire logic                 s_axis_tuser,  // first_byte
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [15:0]               m_axis_tdata,  // payload_byte[7:0], payload_offset[15:8]
  output logic                      m_axis_tlast,  // payload_last
  output logic [2:0]                m_axis_tuser,  // payload_valid, outcome_valid, found
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [OUI_W-1:0]     cfg_wdata_i
);

  cfg_t    cfg;
  result_t res;

  logic        in_valid_q, in_valid_d;
  logic [23:0] in_data_q;
  logic        in_first_q;
  logic        out_valid_q, out_valid_d;
  result_t     out_res_q;
  logic        in_xfer, advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  kdes_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  kdes_walker u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (in_data_q[7:0]),
    .flen_i  (in_data_q[23:8]),
    .first_i (in_first_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = 1'b1;
    else if (m_axis_tready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload stages: hold unless a transfer moves them.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_data_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
    end
    if (advance) out_res_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.payload_offset, out_res_q.payload_byte};
  assign m_axis_tlast  = out_res_q.payload_last;
  assign m_axis_tuser  = {out_res_q.found, out_res_q.outcome_valid, out_res_q.payload_valid};

  `KDES_ASSERT_NOW(a_found_needs_outcome, clk_i, rst_ni, out_valid_q && out_res_q.found, out_res_q.outcome_valid)
  `KDES_ASSERT_NOW(a_last_needs_payload, clk_i, rst_ni, out_valid_q && out_res_q.payload_last, out_res_q.payload_valid)
  `KDES_ASSERT_NOW(a_payload_or_outcome, clk_i, rst_ni, out_valid_q, !(out_res_q.payload_valid && out_res_q.outcome_valid))
  `KDES_ASSERT_NEXT(a_step_fills_output, clk_i, rst_ni, advance, out_valid_q)

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import kdes_pkg::*;

  typedef enum int {EL_MATCH, EL_NEAR, EL_ANY, EL_SHORT_MARK, EL_UNDERSIZE} elem_kind_e;

  // Tracks the element walk per accepted byte and holds the outputs still owed.
  class kde_search_ledger;
    logic [OUI_W-1:0]  oui;
    logic [TYPE_W-1:0] dtype;
    logic [LEN_W-1:0]  min_len;
    logic [FLEN_W-1:0] bytes_left;
    logic [LEN_W-1:0]  elem_len;
    logic [LEN_W-1:0]  elem_off;
    logic [TYPE_W-1:0] elem_type;
    bit                hdr_ok;
    phase_e            phase;
    result_t           due[$];
    int                errors;
    int                n_bytes;
    int                n_found;
    int                n_failed;
    int                n_payload;

    function new();
      oui        = OUI_RESET;
      dtype      = DATA_TYPE_RESET;
      min_len    = MIN_LEN_RESET;
      bytes_left = '0;
      elem_len   = '0;
      elem_off   = '0;
      elem_type  = '0;
      hdr_ok     = 1'b0;
      phase      = PH_IDLE;
      errors     = 0;
      n_bytes    = 0;
      n_found    = 0;
      n_failed   = 0;
      n_payload  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [OUI_W-1:0] val);
      case (idx)
        CFG_IDX_OUI:       oui = val;
        CFG_IDX_DATA_TYPE: dtype = val[TYPE_W-1:0];
        CFG_IDX_MIN_LEN:   min_len = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // A minimum below the header size acts as the header size.
    function logic [LEN_W-1:0] eff_min();
      return (min_len < HDR_LEN) ? HDR_LEN : min_len;
    endfunction

    function void take_byte(logic [7:0] b, logic [FLEN_W-1:0] flen, bit sof);
      result_t          r;
      logic [LEN_W-1:0] off;
      logic [7:0]       want;
      bit               walk;
      bit               advance;
      r       = '0;
      walk    = 1'b0;
      advance = 1'b1;
      n_bytes++;
      if (sof) begin
        bytes_left = flen;
        elem_len   = '0;
        elem_off   = '0;
        elem_type  = '0;
        hdr_ok     = 1'b0;
        if (flen < HDR_LEN) begin
          r.outcome_valid = 1'b1;
          phase = PH_DONE;
        end else begin
          phase = PH_WALK;
          walk  = 1'b1;
        end
      end else if (phase == PH_WALK) begin
        walk = 1'b1;
      end else if (phase == PH_STREAM) begin
        r.payload_valid  = 1'b1;
        r.payload_byte   = b;
        r.payload_offset = 8'(elem_off - HDR_LEN);
        if (elem_off + 1 >= elem_len) begin
          r.payload_last = 1'b1;
          phase = PH_DONE;
        end else begin
          elem_off = elem_off + 1'b1;
        end
      end

      if (walk) begin
        off = elem_off;
        if (off == 0) begin
          elem_type = b;
          hdr_ok    = 1'b1;
        end else if (off == 1) begin
          elem_len = {1'b0, b} + 9'd2;
          // malformed, overrunning, or too short to match with no room for another
          if ((elem_type == KDE_MARK && elem_len < HDR_LEN) || elem_len > bytes_left ||
              (elem_len < eff_min() && bytes_left - elem_len < HDR_LEN)) begin
            r.outcome_valid = 1'b1;
            phase   = PH_DONE;
            advance = 1'b0;
          end
        end else if (off <= 4) begin
          want = 8'(oui >> (8 * (4 - off)));
          if (b != want) hdr_ok = 1'b0;
        end else if (off == 5) begin
          if (b != dtype) hdr_ok = 1'b0;
          if (elem_len >= eff_min()) begin
            if (hdr_ok) begin
              r.outcome_valid = 1'b1;
              r.found         = 1'b1;
              phase   = PH_DONE;
              advance = 1'b0;
              if (elem_len > HDR_LEN) begin
                phase    = PH_STREAM;
                elem_off = HDR_LEN;
              end
            end else if (bytes_left - elem_len < HDR_LEN) begin
              r.outcome_valid = 1'b1;
              phase   = PH_DONE;
              advance = 1'b0;
            end
          end
        end
        if (advance) begin
          if (off >= 1 && off + 1 >= elem_len) begin
            bytes_left = bytes_left - elem_len;
            elem_off   = '0;
          end else begin
            elem_off = off + 1'b1;
          end
        end
      end

      if (r.outcome_valid) begin
        if (r.found) n_found++;
        else n_failed++;
      end
      if (r.payload_valid) n_payload++;
      due.push_back(r);
    endfunction

    function void cmp(string fld, int unsigned want_v, int unsigned got_v);
      if (want_v != got_v) begin
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fld, want_v, got_v);
        errors++;
      end
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (due.size() == 0) begin
        $display("%0t: output transfer with nothing pending, got 0x%0h", $time, got);
        errors++;
        return;
      end
      want = due.pop_front();
      cmp("payload_valid", want.payload_valid, got.payload_valid);
      cmp("payload_byte", want.payload_byte, got.payload_byte);
      cmp("payload_offset", want.payload_offset, got.payload_offset);
      cmp("payload_last", want.payload_last, got.payload_last);
      cmp("outcome_valid", want.outcome_valid, got.outcome_valid);
      cmp("found", want.found, got.found);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  wire                  s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  wire                  m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  wire  [15:0]          m_axis_tdata;
  wire                  m_axis_tlast;
  wire  [2:0]           m_axis_tuser;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_IDX_OUI;
  logic [OUI_W-1:0]     cfg_wdata_i = '0;

  bit                   calm = 1'b0;
  logic [7:0]           frame_q[$];
  kde_search_ledger     ledger;

  kde_element_search_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 24);
  end

  // Note the input transfer first so a same-edge output can never run ahead of it.
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        ledger.take_byte(s_axis_tdata[7:0], s_axis_tdata[23:8], s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.payload_valid  = m_axis_tuser[0];
        got.outcome_valid  = m_axis_tuser[1];
        got.found          = m_axis_tuser[2];
        got.payload_byte   = m_axis_tdata[7:0];
        got.payload_offset = m_axis_tdata[15:8];
        got.payload_last   = m_axis_tlast;
        ledger.match_result(got);
      end
    end
  end

  task automatic push_byte(logic [7:0] b, logic [FLEN_W-1:0] flen, bit sof);
    while (!calm && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {flen, b};
    s_axis_tuser  <= sof;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_frame(int n, logic [FLEN_W-1:0] flen);
    int k;
    for (k = 0; k < n; k++) push_byte(frame_q[k], flen, k == 0);
  endtask

  // Hold the input side until every owed output transfer has been seen.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (ledger.due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_cfg(logic [OUI_W-1:0] oui, logic [TYPE_W-1:0] dtype,
                           logic [LEN_W-1:0] mlen);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_IDX_OUI;
    cfg_wdata_i <= oui;
    @(posedge clk_i);
    ledger.set_reg(CFG_IDX_OUI, oui);
    cfg_idx_i   <= CFG_IDX_DATA_TYPE;
    cfg_wdata_i <= OUI_W'(dtype);
    @(posedge clk_i);
    ledger.set_reg(CFG_IDX_DATA_TYPE, OUI_W'(dtype));
    cfg_idx_i   <= CFG_IDX_MIN_LEN;
    cfg_wdata_i <= OUI_W'(mlen);
    @(posedge clk_i);
    ledger.set_reg(CFG_IDX_MIN_LEN, OUI_W'(mlen));
    cfg_we_i    <= 1'b0;
  endtask

  function automatic void add_element();
    elem_kind_e       kind;
    logic [LEN_W-1:0] eff;
    logic [7:0]       hdr[4];
    logic [7:0]       t;
    int               total;
    int               len_b;
    int               bad;
    int               k;
    int               r;
    r = $urandom_range(99);
    if (r < 35) kind = EL_MATCH;
    else if (r < 60) kind = EL_NEAR;
    else if (r < 78) kind = EL_ANY;
    else if (r < 86) kind = EL_SHORT_MARK;
    else kind = EL_UNDERSIZE;
    eff    = ledger.eff_min();
    hdr[0] = ledger.oui[23:16];
    hdr[1] = ledger.oui[15:8];
    hdr[2] = ledger.oui[7:0];
    hdr[3] = ledger.dtype;
    case (kind)
      EL_MATCH, EL_NEAR: begin
        if (eff <= 257 && $urandom_range(9) != 0) total = eff + $urandom_range(0, 12);
        else total = $urandom_range(6, 257);
        if (total > 257) total = 257;
        frame_q.push_back(($urandom_range(1) != 0) ? KDE_MARK : 8'($urandom));
        frame_q.push_back(8'(total - 2));
        // spoil one header byte for a near miss
        bad = (kind == EL_NEAR) ? $urandom_range(0, 3) : -1;
        for (k = 0; k < 4; k++) begin
          frame_q.push_back((k == bad) ? hdr[k] ^ 8'($urandom_range(1, 255)) : hdr[k]);
        end
        for (k = 6; k < total; k++) frame_q.push_back(8'($urandom));
      end
      EL_ANY: begin
        len_b = ($urandom_range(19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16);
        frame_q.push_back(8'($urandom));
        frame_q.push_back(8'(len_b));
        for (k = 0; k < len_b; k++) frame_q.push_back(8'($urandom));
      end
      EL_SHORT_MARK: begin
        len_b = $urandom_range(0, 3);
        frame_q.push_back(KDE_MARK);
        frame_q.push_back(8'(len_b));
        for (k = 0; k < len_b; k++) frame_q.push_back(8'($urandom));
      end
      default: begin
        // header may agree with the filter, but the element is below the minimum
        len_b = $urandom_range(0, (eff > 257) ? 255 : eff - 3);
        t = 8'($urandom);
        if (t == KDE_MARK && len_b < 4) t = 8'h30;
        frame_q.push_back(t);
        frame_q.push_back(8'(len_b));
        for (k = 0; k < len_b; k++) frame_q.push_back((k < 4) ? hdr[k] : 8'($urandom));
      end
    endcase
  endfunction

  task automatic run_frames(int budget);
    int sent;
    int total;
    int flen;
    int n;
    int r;
    sent = 0;
    while (sent < budget) begin
      // stray byte; ignored unless a search is still open
      if ($urandom_range(11) == 0) begin
        push_byte(8'($urandom), 16'($urandom), 1'b0);
        sent++;
      end
      frame_q.delete();
      repeat ($urandom_range(1, 4)) add_element();
      total = frame_q.size();
      r = $urandom_range(99);
      if (r < 62) flen = total;
      else if (r < 80) flen = total + $urandom_range(1, 8);
      else if (r < 93) flen = total - $urandom_range(1, (total < 8) ? total : 8);
      else flen = $urandom_range(0, 65535);
      while (frame_q.size() < flen && frame_q.size() < total + 8) begin
        frame_q.push_back(8'($urandom));
      end
      n = frame_q.size();
      // cut some frames short with the next first byte
      if ($urandom_range(9) == 0) n = $urandom_range(1, n);
      // keep the byte count near the budget
      if (n > budget - sent) n = (budget - sent > 0) ? budget - sent : 1;
      send_frame(n, 16'(flen));
      sent += n;
    end
  endtask

  initial begin
    ledger = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // byte before any frame start
    push_byte(8'h00, 16'h0000, 1'b0);
    // frame too short to hold a header
    push_byte(8'hDD, 16'd0, 1'b1);
    // exact-size match, no data bytes
    frame_q = '{8'hDD, 8'h04, 8'h00, 8'h0F, 8'hAC, 8'h01};
    send_frame(6, 16'd6);
    // marker element shorter than a header
    frame_q = '{8'hDD, 8'h03};
    send_frame(2, 16'hFFFF);
    // element longer than the frame
    frame_q = '{8'h30, 8'h07};
    send_frame(2, 16'd8);
    // undersized element with no room left after it
    frame_q = '{8'h30, 8'h00};
    send_frame(2, 16'd7);
    // data type differs, too little room for another element
    frame_q = '{8'hDD, 8'h04, 8'h00, 8'h0F, 8'hAC, 8'h02, 8'h5A};
    send_frame(7, 16'd7);
    // match with two data bytes
    frame_q = '{8'hDD, 8'h06, 8'h00, 8'h0F, 8'hAC, 8'h01, 8'hFF, 8'h00};
    send_frame(8, 16'd8);
    drain();

    apply_cfg(24'($urandom), 8'($urandom), 9'd6);
    run_frames(140);
    drain();
    run_frames(140);
    drain();
    apply_cfg(24'h000000, 8'h00, 9'd257);
    run_frames(400);
    drain();
    apply_cfg(24'hFFFFFF, 8'hFF, 9'd0);
    run_frames(250);
    drain();
    calm = 1'b1;
    apply_cfg(24'h506F9A, 8'($urandom), 9'($urandom_range(6, 40)));
    run_frames(280);
    drain();
    calm = 1'b0;
    apply_cfg(OUI_RESET, DATA_TYPE_RESET, 9'd511);
    run_frames(200);
    drain();
    apply_cfg(24'($urandom), 8'($urandom), 9'($urandom_range(6, 20)));
    run_frames(240);
    drain();

    $display("run: %0d bytes in, %0d matches, %0d failed searches, %0d data bytes out",
             ledger.n_bytes, ledger.n_found, ledger.n_failed, ledger.n_payload);
    $display("filters: reset, all-zero and all-one keys, minimum 0/6/257/511, random keys");
    if (ledger.errors == 0 && ledger.due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
